// ----- src/go_back_n_sender_window_unit_assert.svh -----
// ---------------------------------------------------------------------------
// Go-Back-N sender window unit - assertion macros
// Shorthand for clocked implications, gated off while reset is low.
// ---------------------------------------------------------------------------
`ifndef GO_BACK_N_SENDER_WINDOW_UNIT_ASSERT_SVH
`define GO_BACK_N_SENDER_WINDOW_UNIT_ASSERT_SVH

// Same-cycle implication.
`define GBN_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gbn: same-cycle check failed");

// Next-cycle implication.
`define GBN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gbn: next-cycle check failed");

`endif

// ----- src/gbn_pkg.sv -----
// ---------------------------------------------------------------------------
// gbn_pkg
// Shared types and constants of the Go-Back-N sender window unit.
// ---------------------------------------------------------------------------
`default_nettype none

package gbn_pkg;

    // Field widths
    localparam int SEQ_W    = 16;          // sequence / ack / segment count
    localparam int NSEQ_W   = SEQ_W + 1;   // next_seq may reach segment_count + 1
    localparam int WIN_W    = 6;
    localparam int TRIES_W  = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam int MAX_WINDOW_DEF = 63;

    // Register reset values
    localparam logic [WIN_W-1:0]   WINDOW_SIZE_RST   = 6'd4;
    localparam logic [TRIES_W-1:0] MAX_TRIES_RST     = 4'd10;
    localparam logic [SEQ_W-1:0]   SEGMENT_COUNT_RST = 16'd0;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TRIES     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_COUNT = 2'd2;

    typedef enum logic [1:0] {
        FN_START    = 2'd0,
        FN_ACK      = 2'd1,
        FN_TEARDOWN = 2'd2,
        FN_TIMEOUT  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        PH_ACTIVE = 2'd0,
        PH_DONE   = 2'd1,
        PH_GAVEUP = 2'd2,
        PH_IDLE   = 2'd3
    } phase_t;

    // Controller -> datapath
    typedef struct packed {
        logic load;         // capture the request
        logic eval;         // apply the event to the window state
        logic emit_send;    // put out one send command
        logic emit_status;  // put out one status item
    } ctrl_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic do_fill;      // event calls for a window fill
        logic can_send;     // next_seq may go out now
        logic more_after;   // and another one after it
    } dp_status_t;

endpackage

`default_nettype wire

// ----- src/gbn_ctrl.sv -----
// ---------------------------------------------------------------------------
// gbn_ctrl
// Sequencer: capture a request, apply it, then emit the burst or a status item.
// ---------------------------------------------------------------------------
`default_nettype none

module gbn_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire gbn_pkg::dp_status_t   dp_stat,
    output gbn_pkg::ctrl_cmd_t         cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_FILL,
        S_STAT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = dp_stat.do_fill ? S_FILL : S_STAT;
            end
            S_FILL:
            begin
                // fill may turn out empty: then a lone status item
                if (dp_stat.can_send)
                begin
                    cmd.emit_send = 1'b1;
                    if (!dp_stat.more_after)
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    cmd.emit_status = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_STAT:
            begin
                cmd.emit_status = 1'b1;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

`default_nettype wire

// ----- src/gbn_datapath.sv -----
// ---------------------------------------------------------------------------
// gbn_datapath
// Config registers, window state, event update and registered result item.
// ---------------------------------------------------------------------------
`default_nettype none

module gbn_datapath #(
    parameter int MAX_WINDOW = gbn_pkg::MAX_WINDOW_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [gbn_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [gbn_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire logic [1:0]                          func,
    input  wire logic [gbn_pkg::SEQ_W-1:0]           ack_num,
    input  wire gbn_pkg::ctrl_cmd_t                  cmd,
    output gbn_pkg::dp_status_t                      dp_stat,
    output logic                                     result_valid,
    output logic                                     send_valid,
    output logic [gbn_pkg::SEQ_W-1:0]                send_seq,
    output logic                                     is_terminal,
    output logic [1:0]                               status,
    output logic                                     last
);

    localparam int CNT_W = $clog2(MAX_WINDOW + 1);

    // Configuration
    logic [gbn_pkg::WIN_W-1:0]   window_size_reg;
    logic [gbn_pkg::TRIES_W-1:0] max_tries_reg;
    logic [gbn_pkg::SEQ_W-1:0]   segment_count_reg;

    // Captured request
    gbn_pkg::func_t              func_reg;
    logic [gbn_pkg::SEQ_W-1:0]   ack_reg;

    // Window state
    logic [gbn_pkg::NSEQ_W-1:0]  window_base_reg, window_base_next;
    logic [gbn_pkg::NSEQ_W-1:0]  next_seq_reg, next_seq_next;
    logic [gbn_pkg::TRIES_W-1:0] retry_count_reg, retry_count_next;
    gbn_pkg::phase_t             phase_reg, phase_next;
    logic [CNT_W-1:0]            burst_cnt_reg;
    logic                        do_fill;

    // Result item
    logic                        result_valid_reg;
    logic                        send_valid_reg;
    logic [gbn_pkg::SEQ_W-1:0]   send_seq_reg;
    logic                        is_terminal_reg;
    gbn_pkg::phase_t             status_reg;
    logic                        last_reg;

    logic [gbn_pkg::WIN_W-1:0]   win_eff;
    logic [gbn_pkg::NSEQ_W-1:0]  limit;
    logic [gbn_pkg::NSEQ_W-1:0]  seg_ext;
    logic [gbn_pkg::NSEQ_W-1:0]  ack_ext;
    logic [gbn_pkg::NSEQ_W-1:0]  ack_inc;
    logic [gbn_pkg::NSEQ_W-1:0]  next_inc;
    logic [CNT_W:0]              cnt_inc;

    // Window size 0 behaves as 1; oversize clamps to MAX_WINDOW.
    always_comb
    begin
        if (window_size_reg == '0)
        begin
            win_eff = gbn_pkg::WIN_W'(1);
        end
        else if (window_size_reg > gbn_pkg::WIN_W'(MAX_WINDOW))
        begin
            win_eff = gbn_pkg::WIN_W'(MAX_WINDOW);
        end
        else
        begin
            win_eff = window_size_reg;
        end
    end

    assign limit    = window_base_reg + gbn_pkg::NSEQ_W'(win_eff);
    assign seg_ext  = {1'b0, segment_count_reg};
    assign ack_ext  = {1'b0, ack_reg};
    assign ack_inc  = ack_ext + gbn_pkg::NSEQ_W'(1);
    assign next_inc = next_seq_reg + gbn_pkg::NSEQ_W'(1);
    assign cnt_inc  = {1'b0, burst_cnt_reg} + (CNT_W+1)'(1);

    assign dp_stat.do_fill    = do_fill;
    assign dp_stat.can_send   = (next_seq_reg < limit) && (next_seq_reg <= seg_ext)
                                && (burst_cnt_reg < CNT_W'(MAX_WINDOW));
    assign dp_stat.more_after = (next_inc < limit) && (next_inc <= seg_ext)
                                && (cnt_inc < (CNT_W+1)'(MAX_WINDOW));

    // Event update
    always_comb
    begin
        window_base_next = window_base_reg;
        next_seq_next    = next_seq_reg;
        retry_count_next = retry_count_reg;
        phase_next       = phase_reg;
        do_fill          = 1'b0;
        case (func_reg)
            gbn_pkg::FN_START:
            begin
                if (phase_reg != gbn_pkg::PH_ACTIVE)
                begin
                    window_base_next = '0;
                    next_seq_next    = '0;
                    retry_count_next = '0;
                    phase_next       = gbn_pkg::PH_ACTIVE;
                    do_fill          = 1'b1;
                end
            end
            gbn_pkg::FN_ACK:
            begin
                // only acks of data actually sent count
                if ((phase_reg == gbn_pkg::PH_ACTIVE) && (ack_ext < next_seq_reg)
                    && (ack_reg < segment_count_reg))
                begin
                    if (ack_inc > window_base_reg)
                    begin
                        window_base_next = ack_inc;
                    end
                    retry_count_next = '0;
                    do_fill          = 1'b1;
                end
            end
            gbn_pkg::FN_TEARDOWN:
            begin
                if ((phase_reg == gbn_pkg::PH_ACTIVE) && (next_seq_reg > seg_ext))
                begin
                    phase_next = gbn_pkg::PH_DONE;
                end
            end
            gbn_pkg::FN_TIMEOUT:
            begin
                if (phase_reg == gbn_pkg::PH_ACTIVE)
                begin
                    if (retry_count_reg >= max_tries_reg)
                    begin
                        phase_next = gbn_pkg::PH_GAVEUP;
                    end
                    else
                    begin
                        retry_count_next = retry_count_reg + gbn_pkg::TRIES_W'(1);
                        next_seq_next    = window_base_reg;   // go back to base
                        do_fill          = 1'b1;
                    end
                end
            end
            default:
            begin
                do_fill = 1'b0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg   <= gbn_pkg::WINDOW_SIZE_RST;
            max_tries_reg     <= gbn_pkg::MAX_TRIES_RST;
            segment_count_reg <= gbn_pkg::SEGMENT_COUNT_RST;
            window_base_reg   <= '0;
            next_seq_reg      <= '0;
            retry_count_reg   <= '0;
            phase_reg         <= gbn_pkg::PH_IDLE;
            burst_cnt_reg     <= '0;
            result_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    gbn_pkg::CFG_WINDOW_SIZE:
                    begin
                        window_size_reg <= cfg_data[gbn_pkg::WIN_W-1:0];
                    end
                    gbn_pkg::CFG_MAX_TRIES:
                    begin
                        max_tries_reg <= cfg_data[gbn_pkg::TRIES_W-1:0];
                    end
                    gbn_pkg::CFG_SEGMENT_COUNT:
                    begin
                        segment_count_reg <= cfg_data[gbn_pkg::SEQ_W-1:0];
                    end
                    default:
                    begin
                        window_size_reg <= window_size_reg;
                    end
                endcase
            end

            if (cmd.eval)
            begin
                window_base_reg <= window_base_next;
                next_seq_reg    <= next_seq_next;
                retry_count_reg <= retry_count_next;
                phase_reg       <= phase_next;
                burst_cnt_reg   <= '0;
            end
            else if (cmd.emit_send)
            begin
                next_seq_reg  <= next_inc;
                burst_cnt_reg <= cnt_inc[CNT_W-1:0];
            end

            result_valid_reg <= cmd.emit_send || cmd.emit_status;
        end
    end

    // Request capture and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= gbn_pkg::func_t'(func);
            ack_reg  <= ack_num;
        end

        if (cmd.emit_send)
        begin
            send_valid_reg  <= 1'b1;
            send_seq_reg    <= next_seq_reg[gbn_pkg::SEQ_W-1:0];
            is_terminal_reg <= (next_seq_reg == seg_ext);
            status_reg      <= phase_reg;
            last_reg        <= !dp_stat.more_after;
        end
        else if (cmd.emit_status)
        begin
            send_valid_reg  <= 1'b0;
            send_seq_reg    <= '0;
            is_terminal_reg <= 1'b0;
            status_reg      <= phase_reg;
            last_reg        <= 1'b1;
        end
    end

    assign result_valid = result_valid_reg;
    assign send_valid   = send_valid_reg;
    assign send_seq     = send_seq_reg;
    assign is_terminal  = is_terminal_reg;
    assign status       = status_reg;
    assign last         = last_reg;

endmodule

`default_nettype wire

// ----- src/go_back_n_sender_window_unit.sv -----
// ---------------------------------------------------------------------------
// go_back_n_sender_window_unit
// Sender-side Go-Back-N window control: events in, send commands out.
// ---------------------------------------------------------------------------
// One request (func, ack_num) is taken when start is high and busy is low.
// Each request yields a burst of send commands, one per cycle, that fills the
// window, or a single status item when nothing is sent. Every result item is
// on the output ports for exactly one cycle, flagged by result_valid; the
// receiver cannot stall, so it must take every item as it comes. The last
// item of a request carries last = 1. A request is captured, its event is
// applied to the window state, and then its items, 1 to the effective
// window size and at most MAX_WINDOW, go out one per cycle from the
// single sequencer with no stall. busy drops on the cycle the final
// item is registered, so the next request may be taken while that item is on
// the ports. Configuration writes (cfg_we, cfg_index, cfg_data) take effect at
// once and belong only in idle time; indexes with no register are dropped.
// ---------------------------------------------------------------------------
`default_nettype none

`include "go_back_n_sender_window_unit_assert.svh"

module go_back_n_sender_window_unit #(
    parameter int MAX_WINDOW = gbn_pkg::MAX_WINDOW_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,

    // configuration write port
    input  wire logic                                cfg_we,
    input  wire logic [gbn_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [gbn_pkg::CFG_DATA_W-1:0]      cfg_data,

    // request
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [1:0]                          func,
    input  wire logic [gbn_pkg::SEQ_W-1:0]           ack_num,

    // result
    output logic                                     result_valid,
    output logic                                     send_valid,
    output logic [gbn_pkg::SEQ_W-1:0]                send_seq,
    output logic                                     is_terminal,
    output logic [1:0]                               status,
    output logic                                     last
);

    gbn_pkg::ctrl_cmd_t  cmd;
    gbn_pkg::dp_status_t dp_stat;

    // Sequencer: capture -> apply -> emit burst or status
    gbn_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .dp_stat (dp_stat),
        .cmd     (cmd)
    );

    // Window state, config registers and the registered result item
    gbn_datapath #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .func         (func),
        .ack_num      (ack_num),
        .cmd          (cmd),
        .dp_stat      (dp_stat),
        .result_valid (result_valid),
        .send_valid   (send_valid),
        .send_seq     (send_seq),
        .is_terminal  (is_terminal),
        .status       (status),
        .last         (last)
    );

    // Sends only go out of an active transfer.
    `GBN_ASSERT_SAME(a_send_active, clk, rst_n, result_valid && send_valid, status == gbn_pkg::PH_ACTIVE)
    // A burst has no gaps: an item that is not last is followed at once.
    `GBN_ASSERT_NEXT(a_burst_contiguous, clk, rst_n, result_valid && !last, result_valid)
    // A terminal flag only rides on a send command.
    `GBN_ASSERT_SAME(a_terminal_is_send, clk, rst_n, result_valid && is_terminal, send_valid)
    // An accepted request always occupies the block the next cycle.
    `GBN_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy && !result_valid)

endmodule

`default_nettype wire
